// ----- design/astavg_pkg.sv -----
// ----------------------------------------------------------------------------
// astavg_pkg
// Shared constants, codes and controller/datapath interface types for the
// aging sensor table.
// ----------------------------------------------------------------------------
package astavg_pkg;

    localparam int ENTRIES = 16;

    localparam int DATA_W   = 32;
    localparam int EXP_W    = 16;
    localparam int LIVE_W   = 5;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int SUM_W    = DATA_W + $clog2(ENTRIES);
    localparam int AGE_W    = DATA_W + 1;
    localparam int DCNT_W   = $clog2(SUM_W);
    localparam int ENTRY_W  = 3 * DATA_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [EXP_W-1:0] EXPIRY_RESET = EXP_W'(60);

    // item commands
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // register index (word select bit of paddr)
    localparam logic REG_EXPIRY = 1'b0;

    typedef struct packed {
        logic             start;     // load item, clear accumulators
        logic             rd_en;     // read entry at idx
        logic [IDX_W-1:0] idx;
        logic             post;      // insert on report / load divider on query
        logic             div_step;  // one quotient bit
        logic             out_load;  // capture result into output register
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic count_zero;
    } t_sts;

endpackage

// ----- design/aging_sensor_table_average.sv -----
// ----------------------------------------------------------------------------
// aging_sensor_table_average
// Table of sensor readings keyed by IPv4 address with expiry on report and
// average of live temperatures on query.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   command, node_address,
//                                            temperature, reading_time,
//                                            now_seconds
//   result    out        o_valid / i_stall   average, live_count, table_full
//   config    in         APB (psel..pready)  expiry_seconds at byte 0
//
// A report walks the table through the entry RAM read port, one entry per
// cycle, then runs the insert step and the result.
// A query with a live entry adds, after the walk, the one-bit-per-cycle
// restoring divider over the 36-bit sum.
// Synchronous active-low reset clears all valid bits and sets expiry to 60.
// A stalled result lets the next transaction run, which then waits in its last cycle.
// ----------------------------------------------------------------------------
module aging_sensor_table_average (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_command,
    input  logic [astavg_pkg::DATA_W-1:0]         i_node_address,
    input  logic signed [astavg_pkg::DATA_W-1:0]  i_temperature,
    input  logic [astavg_pkg::DATA_W-1:0]         i_reading_time,
    input  logic [astavg_pkg::DATA_W-1:0]         i_now_seconds,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [astavg_pkg::DATA_W-1:0]  o_average,
    output logic [astavg_pkg::LIVE_W-1:0]         o_live_count,
    output logic                                  o_table_full,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [astavg_pkg::PADDR_W-1:0]        paddr,
    input  logic [astavg_pkg::PDATA_W-1:0]        pwdata,
    output logic [astavg_pkg::PDATA_W-1:0]        prdata,
    output logic                                  pready
);
    import astavg_pkg::*;

    logic [EXP_W-1:0] r_expiry;
    logic             cfg_wr;
    logic             sel_expiry;
    t_cmd             cmd;
    t_sts             sts;

    assign pready     = 1'b1;
    assign sel_expiry = (paddr[PADDR_W-1] == REG_EXPIRY);
    assign cfg_wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= EXPIRY_RESET;
        end else if (cfg_wr && sel_expiry) begin
            r_expiry <= pwdata[EXP_W-1:0];
        end
    end

    assign prdata = sel_expiry ? PDATA_W'(r_expiry) : '0;

    astavg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    astavg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_expiry       (r_expiry),
        .i_command      (i_command),
        .i_node_address (i_node_address),
        .i_temperature  (i_temperature),
        .i_reading_time (i_reading_time),
        .i_now_seconds  (i_now_seconds),
        .o_average      (o_average),
        .o_live_count   (o_live_count),
        .o_table_full   (o_table_full)
    );

endmodule

// ----- design/astavg_ram.sv -----
// ----------------------------------------------------------------------------
// astavg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module astavg_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/astavg_ctrl.sv -----
// ----------------------------------------------------------------------------
// astavg_ctrl
// Sequencer: accepts an item, walks the table, runs the insert step and the
// divider (query only), then hands the result to the output register.
// ----------------------------------------------------------------------------
module astavg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  astavg_pkg::t_sts  i_sts,
    output astavg_pkg::t_cmd  o_cmd
);
    import astavg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(SUM_W - 1);

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_dcnt       = r_dcnt;
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        n_out_valid  = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WAIT: begin
                n_state = S_POST;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_dcnt     = '0;
                if (i_sts.is_query && !i_sts.count_zero) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + 1'b1;
                if (r_dcnt == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- design/astavg_dp.sv -----
// ----------------------------------------------------------------------------
// astavg_dp
// Datapath: item registers, entry valid bits, entry RAM, walk evaluation,
// live sum and count, restoring divider and result register.
// ----------------------------------------------------------------------------
module astavg_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  astavg_pkg::t_cmd               i_cmd,
    output astavg_pkg::t_sts               o_sts,
    input  logic [astavg_pkg::EXP_W-1:0]   i_expiry,
    input  logic                           i_command,
    input  logic [astavg_pkg::DATA_W-1:0]  i_node_address,
    input  logic signed [astavg_pkg::DATA_W-1:0] i_temperature,
    input  logic [astavg_pkg::DATA_W-1:0]  i_reading_time,
    input  logic [astavg_pkg::DATA_W-1:0]  i_now_seconds,
    output logic signed [astavg_pkg::DATA_W-1:0] o_average,
    output logic [astavg_pkg::LIVE_W-1:0]  o_live_count,
    output logic                           o_table_full
);
    import astavg_pkg::*;

    // item registers
    logic              r_command;
    logic [DATA_W-1:0] r_addr, r_temp, r_stamp, r_now;

    // table state
    logic [ENTRIES-1:0] r_valid;
    logic               r_ev_vld;
    logic [IDX_W-1:0]   r_ev_idx;

    // walk accumulators
    logic               r_found;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic               r_full;

    // divider
    logic [SUM_W-1:0]   r_quo;
    logic [CNT_W:0]     r_rem;
    logic               r_neg;

    // result register
    logic [DATA_W-1:0]  r_out_avg;
    logic [LIVE_W-1:0]  r_out_cnt;
    logic               r_out_full;

    logic [ENTRY_W-1:0] rd_word;
    logic [DATA_W-1:0]  rd_addr, rd_temp, rd_stamp;
    logic [AGE_W-1:0]   age;
    logic [AGE_W-1:0]   limit;
    logic               expired;
    logic               ev_live_in, ev_keep, ev_match;
    logic               ev_we, ins_we;
    logic               is_report;
    logic [SUM_W-1:0]   temp_ext;
    logic [SUM_W-1:0]   sum_mag;
    logic [CNT_W:0]     rem_shift;
    logic [CNT_W:0]     divisor;
    logic               rem_ge;
    logic [SUM_W-1:0]   quo_signed;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    assign rd_addr  = rd_word[3*DATA_W-1:2*DATA_W];
    assign rd_temp  = rd_word[2*DATA_W-1:DATA_W];
    assign rd_stamp = rd_word[DATA_W-1:0];

    assign is_report = (r_command == CMD_REPORT);

    // signed age; stamps in the future never expire
    assign age     = {1'b0, r_now} - {1'b0, rd_stamp};
    assign limit   = {{(AGE_W - EXP_W){1'b0}}, i_expiry};
    assign expired = $signed(age) > $signed(limit);

    assign ev_live_in = r_ev_vld && r_valid[r_ev_idx];
    assign ev_keep    = ev_live_in && !expired;
    assign ev_match   = ev_keep && (rd_addr == r_addr);
    assign ev_we      = ev_match && is_report;
    assign ins_we     = i_cmd.post && is_report && !r_found && r_free_found;

    assign temp_ext = SUM_W'($signed(rd_temp));
    assign sum_mag  = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;

    assign rem_shift = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign divisor   = {1'b0, r_count};
    assign rem_ge    = (rem_shift >= divisor);

    assign quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    assign ram_we    = ev_we || ins_we;
    assign ram_waddr = ins_we ? r_free_idx : r_ev_idx;
    assign ram_wdata = {r_addr, r_temp, r_stamp};

    astavg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.idx),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ev_vld <= 1'b0;
        end else begin
            r_ev_vld <= i_cmd.rd_en;
            if (ev_live_in && expired && is_report) begin
                r_valid[r_ev_idx] <= 1'b0;
            end
            if (ins_we) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx <= i_cmd.idx;
        if (i_cmd.start) begin
            r_command    <= i_command;
            r_addr       <= i_node_address;
            r_temp       <= i_temperature;
            r_stamp      <= i_reading_time;
            r_now        <= i_now_seconds;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_full       <= 1'b0;
        end else if (r_ev_vld) begin
            if (ev_match) begin
                r_found <= 1'b1;
            end
            // lowest entry that is free once this walk step is done
            if (!ev_keep && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_ev_idx;
            end
            if (ev_keep) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + temp_ext;
            end
        end else if (i_cmd.post) begin
            if (is_report && !r_found) begin
                if (r_free_found) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= sum_mag;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? (rem_shift - divisor) : rem_shift;
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (!is_report && (r_count != '0)) begin
                r_out_avg <= quo_signed[DATA_W-1:0];
            end else begin
                r_out_avg <= '0;
            end
            r_out_cnt  <= LIVE_W'(r_count);
            r_out_full <= r_full;
        end
    end

    assign o_sts.is_query   = (r_command == CMD_QUERY);
    assign o_sts.count_zero = (r_count == '0);

    assign o_average    = r_out_avg;
    assign o_live_count = r_out_cnt;
    assign o_table_full = r_out_full;

endmodule

// ----- design/astavg_checker.sv -----
// ----------------------------------------------------------------------------
// astavg_checker
// Port-level checks for the aging sensor table, bound to the top level.
// ----------------------------------------------------------------------------
module astavg_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_valid,
    input  logic                                  i_stall,
    input  logic signed [astavg_pkg::DATA_W-1:0]  o_average,
    input  logic [astavg_pkg::LIVE_W-1:0]         o_live_count,
    input  logic                                  o_table_full
);
    import astavg_pkg::*;

    localparam logic [LIVE_W-1:0] FULL_COUNT = LIVE_W'(ENTRIES);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_average)
            && $stable(o_live_count) && $stable(o_table_full))
        else $error("result changed while stalled");

    // a drop only happens with every entry live, and reports carry no average
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_live_count == FULL_COUNT && o_average == '0)
        else $error("table_full without a full table");

    // empty table averages to zero
    a_empty_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_live_count == '0 |-> o_average == '0)
        else $error("nonzero average with no live entries");

    // no result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind aging_sensor_table_average astavg_checker u_astavg_checker (.*);
